// File: rtl/core/flc_pkg.sv
package flc_pkg;

   // Output word width, Q5.30
   localparam int RESULT_BITS = 36;

   // Register port widths
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // Register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_TAP_COUNT = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE      = 4'd1;

   // Input word commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Coefficient placement modes
   localparam logic MODE_CONV = 1'b0;
   localparam logic MODE_CORR = 1'b1;

   // Control carried alongside each pipeline stage
   typedef struct packed {
      logic vld;
      logic last;
   } stage_ctl_type;

endpackage

// File: rtl/core/flc_channels.sv
// Input word channel: coefficient loads and samples
interface flc_req_if #(
   parameter int IDX_BITS    = 4,
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [IDX_BITS-1:0]           coef_index;
   logic signed [SAMPLE_BITS-1:0] value;
   logic                          last;

   modport source (output valid, cmd, coef_index, value, last, input ready);
   modport sink   (input valid, cmd, coef_index, value, last, output ready);
endinterface

// Result word channel
interface flc_rsp_if;
   import flc_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [RESULT_BITS-1:0] result;
   logic                          last_of_run;

   modport source (output valid, result, last_of_run, input ready);
   modport sink   (input valid, result, last_of_run, output ready);
endinterface

// Register write channel
interface flc_csr_if;
   import flc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/flc_sum_pipe.sv
module flc_sum_pipe #(
   parameter int MAX_TAPS    = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  flc_pkg::stage_ctl_type        ent,
   input  logic signed [SAMPLE_BITS-1:0] lane_x [MAX_TAPS],
   input  logic signed [SAMPLE_BITS-1:0] lane_c [MAX_TAPS],
   input  logic [$clog2(MAX_TAPS+1)-1:0] taps,
   output logic                          entry_en,
   flc_rsp_if.source                     rsp_bus
);
   import flc_pkg::*;

   localparam int TC_W  = $clog2(MAX_TAPS + 1);
   localparam int LVL   = $clog2(MAX_TAPS);
   localparam int NODES = 1 << LVL;
   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + LVL;

   logic signed [PROD_W-1:0]      prod [MAX_TAPS];
   logic signed [ACC_W-1:0]       leaf_in [NODES];
   logic signed [ACC_W-1:0]       heap_ff [1:2*NODES-1];
   stage_ctl_type                 ctl_ff [LVL+1];
   logic [LVL+1:0]                stage_en;
   logic                          out_vld_ff;
   logic                          out_last_ff;
   logic signed [RESULT_BITS-1:0] out_result_ff;
   logic signed [RESULT_BITS-1:0] out_result_in;

   // Stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      stage_en[LVL+1] = !out_vld_ff || rsp_bus.ready;
      for (int s = LVL; s >= 0; s--) begin
         stage_en[s] = !ctl_ff[s].vld || stage_en[s+1];
      end
   end

   assign entry_en = stage_en[0];

   // One multiplier per lane, lanes at or above the tap count read as zero
   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         prod[k] = lane_x[k] * lane_c[k];
      end
      for (int k = 0; k < NODES; k++) begin
         leaf_in[k] = '0;
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
         if (TC_W'(k) < taps) begin
            leaf_in[k] = ACC_W'(prod[k]);
         end
      end
   end

   // Product registers form the leaves of the tree
   for (genvar k = 0; k < NODES; k++) begin : g_leaf
      always_ff @(posedge clock) begin
         if (stage_en[0]) begin
            heap_ff[NODES+k] <= leaf_in[k];
         end
      end
   end

   // Registered adder tree, node i sums nodes 2i and 2i+1
   for (genvar i = 1; i < NODES; i++) begin : g_node
      localparam int STAGE = LVL - ($clog2(i + 1) - 1);
      always_ff @(posedge clock) begin
         if (stage_en[STAGE]) begin
            heap_ff[i] <= heap_ff[2*i] + heap_ff[2*i+1];
         end
      end
   end

   // Control travels with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LVL; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         if (stage_en[0]) begin
            ctl_ff[0] <= ent;
         end
         for (int s = 1; s <= LVL; s++) begin
            if (stage_en[s]) begin
               ctl_ff[s] <= ctl_ff[s-1];
            end
         end
      end
   end

   // Fit the exact sum into the result width
   if (ACC_W > RESULT_BITS) begin : g_sat
      logic fits;
      always_comb begin
         fits = (heap_ff[1][ACC_W-1:RESULT_BITS-1] == '0) ||
                (heap_ff[1][ACC_W-1:RESULT_BITS-1] == '1);
         if (fits) begin
            out_result_in = heap_ff[1][RESULT_BITS-1:0];
         end else if (heap_ff[1][ACC_W-1]) begin
            out_result_in = {1'b1, {(RESULT_BITS-1){1'b0}}};
         end else begin
            out_result_in = {1'b0, {(RESULT_BITS-1){1'b1}}};
         end
      end
   end else begin : g_ext
      assign out_result_in = RESULT_BITS'(heap_ff[1]);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else if (stage_en[LVL+1]) begin
         out_vld_ff  <= ctl_ff[LVL].vld;
         out_last_ff <= ctl_ff[LVL].last;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[LVL+1]) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.result      = out_result_ff;
   assign rsp_bus.last_of_run = out_last_ff;

   // A full output that is not taken stalls the root stage
   a_root_stall: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_bus.ready |-> !stage_en[LVL+1])
      else $error("root stage advanced into a held output");

   // An empty entry stage always takes a word
   a_entry_free: assert property (@(posedge clock) disable iff (reset)
      !ctl_ff[0].vld |-> entry_en)
      else $error("entry stage refused while empty");

   // Root content reaches the output register in the cycle after the output stage moves
   a_out_follow: assert property (@(posedge clock) disable iff (reset)
      stage_en[LVL+1] |=> out_vld_ff == $past(ctl_ff[LVL].vld))
      else $error("output valid does not follow root stage");

endmodule

// File: rtl/core/full_linear_convolution.sv
// A sample word passes one product stage, a registered adder tree and one output register
// before it leaves as a result word. The input takes one sample word per cycle while the
// output is not stalled; a sample marked last blocks the input while the tap_count-1
// tail results are issued.
// Reset (synchronous, active high) empties the pipeline, clears coefficients and the
// delay line, and sets tap_count to MAX_TAPS and mode to convolution.
module full_linear_convolution #(
   parameter int MAX_TAPS    = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   flc_req_if.sink   req_bus,
   flc_rsp_if.source rsp_bus,
   flc_csr_if.sink   csr_bus
);
   import flc_pkg::*;

   localparam int IDX_W = $clog2(MAX_TAPS);
   localparam int TC_W  = $clog2(MAX_TAPS + 1);
   localparam int DL    = MAX_TAPS - 1;

   logic [TC_W-1:0]               tap_count_ff;
   logic                          mode_ff;
   logic [TC_W-1:0]               eff_taps;
   logic [TC_W-1:0]               flush_cnt_ff;
   logic                          flushing;
   logic                          entry_en;
   logic                          req_fire;
   logic                          load_fire;
   logic                          smp_fire;
   logic                          ent_fire;
   logic                          ent_last;
   logic signed [SAMPLE_BITS-1:0] x_new;
   logic signed [SAMPLE_BITS-1:0] coef_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] delay_ff [DL];
   logic signed [SAMPLE_BITS-1:0] lane_x [MAX_TAPS];
   logic [TC_W-1:0]               idx_ext;
   logic [TC_W-1:0]               corr_addr;
   logic                          coef_we;
   logic [IDX_W-1:0]              coef_addr;
   logic                          dl_zero;
   stage_ctl_type                 ent;

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TC_W'(MAX_TAPS);
         mode_ff      <= MODE_CONV;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == REG_TAP_COUNT) begin
            tap_count_ff <= csr_bus.data[TC_W-1:0];
         end else if (csr_bus.index == REG_MODE) begin
            mode_ff <= csr_bus.data[0];
         end
      end
   end

   // Tap count clamped to 1..MAX_TAPS
   always_comb begin
      if (tap_count_ff == '0) begin
         eff_taps = TC_W'(1);
      end else if (tap_count_ff > TC_W'(MAX_TAPS)) begin
         eff_taps = TC_W'(MAX_TAPS);
      end else begin
         eff_taps = tap_count_ff;
      end
   end

   // Input handshake; the tail flush owns the entry stage
   assign flushing      = flush_cnt_ff != '0;
   assign req_bus.ready = entry_en && !flushing;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign load_fire     = req_fire && (req_bus.cmd == CMD_LOAD);
   assign smp_fire      = req_fire && (req_bus.cmd == CMD_SAMPLE);
   assign ent_fire      = smp_fire || (flushing && entry_en);

   // Entry word: live sample, or a zero during the flush
   always_comb begin
      if (flushing) begin
         x_new    = '0;
         ent_last = flush_cnt_ff == TC_W'(1);
      end else begin
         x_new    = req_bus.value;
         ent_last = req_bus.last && (eff_taps == TC_W'(1));
      end
      ent.vld  = flushing || (req_bus.valid && (req_bus.cmd == CMD_SAMPLE));
      ent.last = ent_last;
   end

   // Flush counter
   always_ff @(posedge clock) begin
      if (reset) begin
         flush_cnt_ff <= '0;
      end else if (smp_fire && req_bus.last && (eff_taps != TC_W'(1))) begin
         flush_cnt_ff <= eff_taps - TC_W'(1);
      end else if (flushing && entry_en) begin
         flush_cnt_ff <= flush_cnt_ff - TC_W'(1);
      end
   end

   // Delay line, newest first; wiped after the final word of a run
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            delay_ff[k] <= '0;
         end
      end else if (ent_fire) begin
         if (ent_last) begin
            for (int k = 0; k < DL; k++) begin
               delay_ff[k] <= '0;
            end
         end else begin
            delay_ff[0] <= x_new;
            for (int k = 1; k < DL; k++) begin
               delay_ff[k] <= delay_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      lane_x[0] = x_new;
      for (int k = 1; k < MAX_TAPS; k++) begin
         lane_x[k] = delay_ff[k-1];
      end
   end

   // Coefficient store; correlation mode mirrors the index
   assign idx_ext   = TC_W'(req_bus.coef_index);
   assign corr_addr = eff_taps - TC_W'(1) - idx_ext;

   always_comb begin
      if (mode_ff == MODE_CORR) begin
         coef_we   = load_fire && (idx_ext < eff_taps);
         coef_addr = corr_addr[IDX_W-1:0];
      end else begin
         coef_we   = load_fire && (idx_ext < TC_W'(MAX_TAPS));
         coef_addr = req_bus.coef_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (coef_we) begin
         coef_ff[coef_addr] <= req_bus.value;
      end
   end

   flc_sum_pipe #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sum_pipe (
      .clock    (clock),
      .reset    (reset),
      .ent      (ent),
      .lane_x   (lane_x),
      .lane_c   (coef_ff),
      .taps     (eff_taps),
      .entry_en (entry_en),
      .rsp_bus  (rsp_bus)
   );

   always_comb begin
      dl_zero = 1'b1;
      for (int k = 0; k < DL; k++) begin
         if (delay_ff[k] != '0) begin
            dl_zero = 1'b0;
         end
      end
   end

   // No input word is taken during a tail flush
   a_flush_block: assert property (@(posedge clock) disable iff (reset)
      flushing |-> !req_bus.ready)
      else $error("input accepted during tail flush");

   // The marked final word leaves a clean delay line
   a_dl_clear: assert property (@(posedge clock) disable iff (reset)
      ent_fire && ent_last |=> dl_zero)
      else $error("delay line not cleared after run");

   // A last sample arms the flush for the remaining taps
   a_flush_arm: assert property (@(posedge clock) disable iff (reset)
      smp_fire && req_bus.last && (eff_taps != TC_W'(1))
      |=> flush_cnt_ff == $past(eff_taps) - TC_W'(1))
      else $error("flush count wrong after last sample");

endmodule

// File: tb/flc_result_checker.sv
// Watches the three channels, predicts every result word from the accepted
// input words and register writes, and compares in order.
module flc_result_checker #(
   parameter int MAX_TAPS = 16
) (
   input  logic clock,
   input  logic reset,
   flc_req_if   req,
   flc_rsp_if   rsp,
   flc_csr_if   csr,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import flc_pkg::*;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] result;
      logic                          last_of_run;
   } conv_word_type;

   conv_word_type      conv_expected[$];
   logic signed [15:0] coef_mem [MAX_TAPS];
   logic signed [15:0] history [MAX_TAPS-1];
   logic [4:0]         tap_reg;
   logic               mode_reg;

   // tap_count clamped to 1..MAX_TAPS
   function automatic int taps_in_use();
      if (tap_reg == 5'd0) return 1;
      if (tap_reg > MAX_TAPS) return MAX_TAPS;
      return int'(tap_reg);
   endfunction

   // One output of the FIR sum, then shift the sample into the history.
   // The exact sum always fits 36 bits at these sizes, so no clamp.
   function automatic logic signed [RESULT_BITS-1:0] filter_step(logic signed [15:0] x);
      longint acc;
      int     n;
      n = taps_in_use();
      acc = longint'(x) * longint'(coef_mem[0]);
      for (int k = 1; k < n; k++)
         acc += longint'(history[k-1]) * longint'(coef_mem[k]);
      for (int k = MAX_TAPS - 2; k > 0; k--)
         history[k] = history[k-1];
      history[0] = x;
      return acc[RESULT_BITS-1:0];
   endfunction

   // Apply one accepted input word to the predicted state
   function automatic void predict_word(logic cmd, logic [3:0] idx,
                                        logic signed [15:0] val, logic lst);
      int            n;
      conv_word_type w;
      n = taps_in_use();
      if (cmd == CMD_LOAD) begin
         if (mode_reg == MODE_CONV) begin
            if (idx < MAX_TAPS) coef_mem[idx] = val;
         end else if (idx < n) begin
            coef_mem[n - 1 - idx] = val;
         end
      end else begin
         w.result      = filter_step(val);
         w.last_of_run = lst && (n == 1);
         conv_expected.push_back(w);
         if (lst) begin
            // tail flush: zeros shifted in until every product has left
            for (int k = 1; k < n; k++) begin
               w.result      = filter_step(16'sd0);
               w.last_of_run = (k == n - 1);
               conv_expected.push_back(w);
            end
            foreach (history[i]) history[i] = '0;
         end
      end
   endfunction

   always @(posedge clock) begin
      conv_word_type want;
      if (reset) begin
         foreach (coef_mem[i]) coef_mem[i] = '0;
         foreach (history[i]) history[i] = '0;
         tap_reg    = 5'd16;
         mode_reg   = MODE_CONV;
         fail_count = 0;
         conv_expected.delete();
      end else begin
         // results first, so a word never matches one predicted this same edge
         if (rsp.valid && rsp.ready) begin
            if (conv_expected.size() == 0) begin
               $display("%0t: result word with nothing expected: result %0d last %0b",
                        $time, rsp.result, rsp.last_of_run);
               fail_count++;
            end else begin
               want = conv_expected.pop_front();
               if (rsp.result !== want.result) begin
                  $display("%0t: result mismatch: expected %0d, got %0d",
                           $time, want.result, rsp.result);
                  fail_count++;
               end
               if (rsp.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                           $time, want.last_of_run, rsp.last_of_run);
                  fail_count++;
               end
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_TAP_COUNT: tap_reg  = csr.data[4:0];
               REG_MODE:      mode_reg = csr.data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            predict_word(req.cmd, req.coef_index, req.value, req.last);
      end
      outstanding <= conv_expected.size();
   end

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import flc_pkg::*;

   localparam int                        DRAIN_CYCLES = 12;
   localparam int                        RANDOM_WORDS = 200;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE    = 4'hF;

   logic clock;
   logic reset;

   flc_req_if req_bus ();
   flc_rsp_if rsp_bus ();
   flc_csr_if csr_bus ();

   int fail_count;
   int outstanding;

   int   words_sent = 0;
   int   taps_now   = 16;
   logic mode_now   = MODE_CONV;
   bit   req_calm   = 0;
   bit   rsp_calm   = 0;
   int   rsp_hold   = 0;

   full_linear_convolution dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   flc_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr         (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int clamp_taps(logic [4:0] t);
      if (t == 5'd0) return 1;
      if (t > 5'd16) return 16;
      return int'(t);
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 20) rsp_hold <= pick_gap();
      end
   end

   task automatic send_word(logic cmd, logic [3:0] idx, logic [15:0] val, logic lst);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.coef_index <= idx;
      req_bus.value      <= val;
      req_bus.last       <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // out-of-range correlation loads are dropped by the block
      if (!(cmd == CMD_LOAD && mode_now == MODE_CORR && idx >= taps_now)) words_sent++;
   endtask

   // hold the sender until every predicted word is out, then let the pipe settle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      drain_results();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == REG_TAP_COUNT) taps_now = clamp_taps(data[4:0]);
      if (idx == REG_MODE) mode_now = data[0];
   endtask

   task automatic set_taps(logic [4:0] t);
      write_reg(REG_TAP_COUNT, {11'($urandom), t});
   endtask

   task automatic set_mode(logic m);
      write_reg(REG_MODE, {15'($urandom), m});
   endtask

   task automatic load_coefs(int n);
      logic [3:0] idx;
      for (int i = 0; i < n; i++) begin
         if (mode_now == MODE_CORR && $urandom_range(0, 7) != 0)
            idx = 4'($urandom_range(0, taps_now - 1));
         else
            idx = 4'($urandom);
         send_word(CMD_LOAD, idx, pick_value(), 1'($urandom));
      end
   endtask

   task automatic run_samples(int len, bit with_last);
      for (int i = 0; i < len; i++)
         send_word(CMD_SAMPLE, 4'($urandom), pick_value(), with_last && (i == len - 1));
   endtask

   // run limit
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int         phase;
      int         goal;
      logic [4:0] edge_taps [6];
      edge_taps = '{5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd1};

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_LOAD;
      req_bus.coef_index <= '0;
      req_bus.value      <= '0;
      req_bus.last       <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // full-scale negative coefficients and full-scale samples of both signs
      for (int i = 0; i < 16; i++) send_word(CMD_LOAD, 4'(i), 16'h8000, 1'b0);
      send_word(CMD_SAMPLE, 4'hF, 16'h8000, 1'b0);
      send_word(CMD_SAMPLE, 4'h0, 16'h8000, 1'b0);
      send_word(CMD_SAMPLE, 4'hA, 16'h7FFF, 1'b0);
      // last bit on a load is ignored
      send_word(CMD_LOAD, 4'd7, 16'h7FFF, 1'b1);
      send_word(CMD_SAMPLE, 4'h5, 16'h8000, 1'b1);

      // one tap, correlation: index beyond the tap count is dropped
      set_taps(5'd1);
      set_mode(MODE_CORR);
      send_word(CMD_LOAD, 4'd0, 16'h7FFF, 1'b1);
      send_word(CMD_LOAD, 4'd9, 16'h1234, 1'b0);
      send_word(CMD_SAMPLE, 4'h3, 16'h7FFF, 1'b1);
      // unmapped register index
      write_reg(REG_SPARE, 16'($urandom));

      // random sequences
      goal  = words_sent + RANDOM_WORDS;
      phase = 0;
      while (words_sent < goal) begin
         req_calm = ($urandom_range(0, 4) == 0);
         rsp_calm = ($urandom_range(0, 4) == 0);
         if (phase < 6) begin
            set_taps(edge_taps[phase]);
            set_mode(phase[0]);
         end else begin
            case ($urandom_range(0, 9))
               0, 1: set_taps(($urandom_range(0, 4) == 0) ? 5'($urandom) :
                              5'($urandom_range(1, 16)));
               2: set_mode(1'($urandom));
               3: drain_results();
               default: ;
            endcase
         end
         if (phase < 6 || $urandom_range(0, 2) == 0) load_coefs($urandom_range(1, taps_now));
         if ($urandom_range(0, 5) == 0)
            run_samples($urandom_range(9, 24), $urandom_range(0, 9) != 0);
         else
            run_samples($urandom_range(1, 8), $urandom_range(0, 9) != 0);
         phase++;
      end
      run_samples(1, 1'b1);

      drain_results();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
